// File: rtl/bet_pkg.sv
// Shared types, constants and helper functions for the button event tracker.
// No dependencies; every other file of the block imports this package.
package bet_pkg;

    localparam int NUM_BUTTONS  = 8;
    localparam int PIN_W        = 8;
    localparam int SCAN_BUTTONS = (NUM_BUTTONS < PIN_W) ? NUM_BUTTONS : PIN_W;
    localparam int BTN_W        = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [15:0] RST_BUTTON_MODES     = 16'd0;
    localparam logic [7:0]  RST_RELEASE_TICKS    = 8'd5;
    localparam logic [15:0] RST_LONG_PRESS_TICKS = 16'd1500;
    localparam logic [15:0] RST_REPEAT_DELAY     = 16'd1000;
    localparam logic [15:0] RST_REPEAT_INTERVAL  = 16'd50;

    typedef enum logic [1:0] {
        EV_DOWN     = 2'd0,
        EV_CLICK_UP = 2'd1,
        EV_LONG     = 2'd2,
        EV_REPEAT   = 2'd3
    } t_event_kind;

    typedef enum logic [1:0] {
        MODE_SIMPLE     = 2'd0,
        MODE_LONG       = 2'd1,
        MODE_MULTI      = 2'd2,
        MODE_SIMPLE_ALT = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUTTON_MODES       = 3'd0,
        CFG_RELEASE_TICKS      = 3'd1,
        CFG_LONG_PRESS_TICKS   = 3'd2,
        CFG_REPEAT_FIRST_DELAY = 3'd3,
        CFG_REPEAT_INTERVAL    = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [15:0] button_modes;
        logic [7:0]  release_ticks;
        logic [15:0] long_press_ticks;
        logic [15:0] repeat_first_delay;
        logic [15:0] repeat_interval;
    } t_cfg;

    typedef struct packed {
        logic              emit;
        t_event_kind       kind;
        logic [BTN_W-1:0]  button;
    } t_result;

    function automatic logic [7:0] sat_inc8(input logic [7:0] value);
        return (value == 8'hFF) ? value : value + 8'd1;
    endfunction

endpackage

// File: rtl/bet_cfg_regs.sv
// Configuration register file of the button event tracker.
// Depends on bet_pkg for the register index codes, reset values and t_cfg.
module bet_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bet_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bet_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output bet_pkg::t_cfg                 o_cfg
);
    import bet_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.button_modes       <= RST_BUTTON_MODES;
            r_cfg.release_ticks      <= RST_RELEASE_TICKS;
            r_cfg.long_press_ticks   <= RST_LONG_PRESS_TICKS;
            r_cfg.repeat_first_delay <= RST_REPEAT_DELAY;
            r_cfg.repeat_interval    <= RST_REPEAT_INTERVAL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BUTTON_MODES:       r_cfg.button_modes       <= i_cfg_wdata;
                CFG_RELEASE_TICKS:      r_cfg.release_ticks      <= i_cfg_wdata[7:0];
                CFG_LONG_PRESS_TICKS:   r_cfg.long_press_ticks   <= i_cfg_wdata;
                CFG_REPEAT_FIRST_DELAY: r_cfg.repeat_first_delay <= i_cfg_wdata;
                CFG_REPEAT_INTERVAL:    r_cfg.repeat_interval    <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/bet_core.sv
// Tracking state and per-tick decision logic of the button event tracker.
// Depends on bet_pkg for the mode and event codes, t_cfg and t_result.
module bet_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic [bet_pkg::PIN_W-1:0] i_pin_levels,
    input  bet_pkg::t_cfg             i_cfg,
    output bet_pkg::t_result          o_result
);
    import bet_pkg::*;

    logic             r_busy, n_busy;
    logic [BTN_W-1:0] r_held_button, n_held_button;
    t_mode            r_held_mode, n_held_mode;
    logic             r_click_sent, n_click_sent;
    logic [7:0]       r_simple_rel, n_simple_rel;
    logic [15:0]      r_hold, n_hold;
    logic [7:0]       r_long_rel, n_long_rel;
    logic             r_long_sent, n_long_sent;
    logic [15:0]      r_delay, n_delay;
    logic [15:0]      r_interval, n_interval;
    logic [7:0]       r_repeat_rel, n_repeat_rel;

    logic             found;
    logic [BTN_W-1:0] scan_idx;
    logic             pressed;
    logic             go_idle;
    logic             emit;
    t_event_kind      kind;
    logic [15:0]      interval_inc;

    always_comb begin
        found    = 1'b0;
        scan_idx = '0;
        for (int i = SCAN_BUTTONS - 1; i >= 0; i--) begin
            if (!i_pin_levels[i]) begin
                found    = 1'b1;
                scan_idx = BTN_W'(i);
            end
        end
    end

    assign pressed      = !i_pin_levels[r_held_button];
    assign interval_inc = r_interval + 16'd1;

    always_comb begin
        n_busy        = r_busy;
        n_held_button = r_held_button;
        n_held_mode   = r_held_mode;
        n_click_sent  = r_click_sent;
        n_simple_rel  = r_simple_rel;
        n_hold        = r_hold;
        n_long_rel    = r_long_rel;
        n_long_sent   = r_long_sent;
        n_delay       = r_delay;
        n_interval    = r_interval;
        n_repeat_rel  = r_repeat_rel;
        go_idle       = 1'b0;
        emit          = 1'b0;
        kind          = EV_DOWN;

        if (!r_busy) begin
            if (found) begin
                go_idle       = 1'b1;
                n_held_button = scan_idx;
                n_held_mode   = t_mode'(i_cfg.button_modes[{scan_idx, 1'b0} +: 2]);
                emit          = 1'b1;
                kind          = EV_DOWN;
            end
        end else begin
            case (r_held_mode)
                MODE_LONG: begin
                    if (pressed) begin
                        if (r_hold < i_cfg.long_press_ticks) begin
                            n_hold = r_hold + 16'd1;
                        end
                        n_long_rel = '0;
                    end else begin
                        n_long_rel = sat_inc8(r_long_rel);
                    end
                    if (n_hold < i_cfg.long_press_ticks
                        && n_long_rel >= i_cfg.release_ticks) begin
                        emit = 1'b1;
                        kind = EV_CLICK_UP;
                    end else if (n_hold >= i_cfg.long_press_ticks && !r_long_sent) begin
                        emit        = 1'b1;
                        kind        = EV_LONG;
                        n_long_sent = 1'b1;
                    end
                    if (n_long_rel >= i_cfg.release_ticks) begin
                        go_idle = 1'b1;
                    end
                end
                MODE_MULTI: begin
                    if (pressed) begin
                        n_repeat_rel = '0;
                        if (r_delay < i_cfg.repeat_first_delay) begin
                            n_delay = r_delay + 16'd1;
                        end else if (interval_inc < i_cfg.repeat_interval) begin
                            n_interval = interval_inc;
                        end else begin
                            n_interval = '0;
                            emit       = 1'b1;
                            kind       = EV_REPEAT;
                        end
                    end else begin
                        n_repeat_rel = sat_inc8(r_repeat_rel);
                        if (n_repeat_rel >= i_cfg.release_ticks) begin
                            emit    = 1'b1;
                            kind    = EV_CLICK_UP;
                            go_idle = 1'b1;
                        end
                    end
                end
                default: begin
                    if (!r_click_sent) begin
                        emit         = 1'b1;
                        kind         = EV_CLICK_UP;
                        n_click_sent = 1'b1;
                    end
                    if (!pressed) begin
                        n_simple_rel = sat_inc8(r_simple_rel);
                        if (n_simple_rel >= i_cfg.release_ticks) begin
                            go_idle = 1'b1;
                        end
                    end
                end
            endcase
        end

        if (go_idle) begin
            n_busy       = !r_busy;
            n_click_sent = 1'b0;
            n_simple_rel = '0;
            n_hold       = '0;
            n_long_rel   = '0;
            n_long_sent  = 1'b0;
            n_delay      = '0;
            n_interval   = '0;
            n_repeat_rel = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_held_button <= '0;
            r_held_mode   <= MODE_SIMPLE;
            r_click_sent  <= 1'b0;
            r_simple_rel  <= '0;
            r_hold        <= '0;
            r_long_rel    <= '0;
            r_long_sent   <= 1'b0;
            r_delay       <= '0;
            r_interval    <= '0;
            r_repeat_rel  <= '0;
        end else if (i_step) begin
            r_busy        <= n_busy;
            r_held_button <= n_held_button;
            r_held_mode   <= n_held_mode;
            r_click_sent  <= n_click_sent;
            r_simple_rel  <= n_simple_rel;
            r_hold        <= n_hold;
            r_long_rel    <= n_long_rel;
            r_long_sent   <= n_long_sent;
            r_delay       <= n_delay;
            r_interval    <= n_interval;
            r_repeat_rel  <= n_repeat_rel;
        end
    end

    assign o_result.emit   = emit;
    assign o_result.kind   = kind;
    assign o_result.button = n_held_button;

endmodule

// File: rtl/button_event_tracker.sv
// Button event tracker: down, click-up, long-click and repeat events from tick items.
// Results are registered from the input register; one item per cycle when not stalled.
// The input register and the result register each hold one item, so a stalled result
// stops new items only when both are full.
// Reset (synchronous, active low) restores default configuration and returns to idle.
// Depends on bet_pkg, bet_cfg_regs and bet_core.
module button_event_tracker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bet_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bet_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [bet_pkg::PIN_W-1:0]      i_pin_levels,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_event_kind,
    output logic [bet_pkg::BTN_W-1:0]      o_button_index
);
    import bet_pkg::*;

    t_cfg             cfg;
    t_result          result;
    logic             step;
    logic             r_in_valid;
    logic [PIN_W-1:0] r_pin_levels;
    logic             r_out_valid;
    t_event_kind      r_event_kind;
    logic [BTN_W-1:0] r_button_index;

    bet_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    bet_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_pin_levels (r_pin_levels),
        .i_cfg        (cfg),
        .o_result     (result)
    );

    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_pin_levels <= i_pin_levels;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= result.emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_event_kind   <= result.kind;
            r_button_index <= result.button;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_kind   = r_event_kind;
    assign o_button_index = r_button_index;

endmodule

// File: rtl/bet_checker.sv
// Port-level checks for the button event tracker, attached by a bind statement.
// Depends on bet_pkg for port widths and on the button_event_tracker port list.
module bet_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_we,
    input logic [bet_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [bet_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic [bet_pkg::PIN_W-1:0]      i_pin_levels,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [1:0]                     o_event_kind,
    input logic [bet_pkg::BTN_W-1:0]      o_button_index
);
    import bet_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("outputs not cleared by reset");

    a_ready_low_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled while the result side is free");

    a_result_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result appeared without an accepted item");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_event_kind) && $stable(o_button_index))
        else $error("stalled result changed");

endmodule

bind button_event_tracker bet_checker u_bet_checker (.*);
